>>> rtl/core/cfps_pkg.sv
// shared types and constants of the closest/farthest pair search
// no dependencies; imported by every module of the block

package cfps_pkg;

  // coordinate, squared distance and root widths
  localparam int COORD_BITS   = 24;
  localparam int SQ_BITS      = 2 * COORD_BITS + 2;
  localparam int ROOT_BITS    = SQ_BITS / 2;
  localparam int IDX_OUT_BITS = 10;
  localparam int MODE_BITS    = 2;
  localparam int POINT_BITS   = 3 * COORD_BITS;

  // input beat selector codes
  typedef enum logic [MODE_BITS-1:0] {
    MODE_LOAD    = 2'd0,
    MODE_COMPARE = 2'd1,
    MODE_END     = 2'd2
  } mode_t;

  // control states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT,
    ST_EMIT
  } state_t;

  // status of the distance pipeline toward the controller
  typedef struct packed {
    logic busy;
    logic hit;
  } dist_stat_t;

  // magnitude of the difference of two signed coordinates
  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] d;
    d = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
    return d[COORD_BITS] ? COORD_BITS'(-d) : COORD_BITS'(d);
  endfunction

endpackage

>>> rtl/core/closest_farthest_pair_search.sv
// top level of the closest/farthest pair search between two point sets
// uses cfps_pkg, cfps_point_mem, cfps_dist_pipe and cfps_isqrt
//
//   port group  direction  beat carries
//   in_*        input      mode, point x/y/z (signed, 10 fraction bits)
//   out_*       output     distance, first/second index, empty, overflow
//   cfg_*       input      find_farthest register
//
// load, ignored or empty-first-set compare beat: the input stays open.
// compare beat: the input closes while the stored first-set points are scanned, one stored point read
//   per cycle, then the four-stage distance pipeline drains.
// end beat: the input closes for 25 root steps, the root handoff and emit; for an empty set
//   only for emit, and longer while the previous result beat is not taken.
// synchronous active-low reset clears the job; the point store is not cleared.

module closest_farthest_pair_search
  import cfps_pkg::*;
#(
  parameter int FIRST_DEPTH  = 1024,
  parameter int SECOND_LIMIT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [MODE_BITS-1:0]          in_mode,
  input  logic signed [COORD_BITS-1:0]  in_point_x,
  input  logic signed [COORD_BITS-1:0]  in_point_y,
  input  logic signed [COORD_BITS-1:0]  in_point_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ROOT_BITS-1:0]          out_distance,
  output logic [IDX_OUT_BITS-1:0]       out_first_index,
  output logic [IDX_OUT_BITS-1:0]       out_second_index,
  output logic                          out_empty_set,
  output logic                          out_overflow,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_find_farthest
);

  localparam int AW  = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
  localparam int FCW = $clog2(FIRST_DEPTH + 1);
  localparam int SCW = $clog2(SECOND_LIMIT + 1);
  localparam int SIW = (SECOND_LIMIT > 1) ? $clog2(SECOND_LIMIT) : 1;

  state_t state_r, state_nxt;

  logic                         find_farthest_r;
  logic [FCW-1:0]               first_count_r;
  logic [SCW-1:0]               second_count_r;
  logic [SQ_BITS-1:0]           best_sq_r;
  logic [AW-1:0]                best_first_r;
  logic [SIW-1:0]               best_second_r;
  logic                         overflow_r;
  logic [AW-1:0]                scan_idx_r;
  logic signed [COORD_BITS-1:0] q_x_r, q_y_r, q_z_r;

  logic                   out_valid_r;
  logic [ROOT_BITS-1:0]   out_distance_r;
  logic [IDX_OUT_BITS-1:0] out_first_r, out_second_r;
  logic                   out_empty_r, out_overflow_r;

  logic accept;
  logic first_full, second_full, set_empty;
  logic ld_ok, ld_drop, cmp_drop, cmp_skip, cmp_go, end_go;
  logic scan_last, slot_free;
  logic issue, scan_step, drain_done, emit, root_start;

  logic [POINT_BITS-1:0]  rd_data;
  dist_stat_t             dstat;
  logic [SQ_BITS-1:0]     d_sq;
  logic [AW-1:0]          d_idx;
  logic                   take;
  logic                   root_busy;
  logic [ROOT_BITS-1:0]   root;

  // beat decode in the idle state
  assign accept      = in_valid && in_ready;
  assign first_full  = (first_count_r == FCW'(FIRST_DEPTH));
  assign second_full = (second_count_r == SCW'(SECOND_LIMIT));
  assign set_empty   = (first_count_r == '0) || (second_count_r == '0);

  assign ld_ok    = accept && (in_mode == MODE_LOAD) && (second_count_r == '0)
                    && !first_full;
  assign ld_drop  = accept && (in_mode == MODE_LOAD) && (second_count_r == '0)
                    && first_full;
  assign cmp_drop = accept && (in_mode == MODE_COMPARE) && second_full;
  assign cmp_skip = accept && (in_mode == MODE_COMPARE) && !second_full
                    && (first_count_r == '0);
  assign cmp_go   = accept && (in_mode == MODE_COMPARE) && !second_full
                    && (first_count_r != '0);
  assign end_go   = accept && (in_mode == MODE_END);

  assign scan_last = (FCW'(scan_idx_r) + FCW'(1)) == first_count_r;
  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmp_go) begin
          state_nxt = ST_SCAN;
        end else if (end_go) begin
          state_nxt = set_empty ? ST_EMIT : ST_ROOT;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!dstat.busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ROOT: begin
        if (!root_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    issue      = 1'b0;
    scan_step  = 1'b0;
    drain_done = 1'b0;
    emit       = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_SCAN: begin
        issue     = 1'b1;
        scan_step = 1'b1;
      end
      ST_DRAIN: drain_done = !dstat.busy;
      ST_ROOT:  in_ready = 1'b0;
      ST_EMIT:  emit = slot_free;
      default:  in_ready = 1'b0;
    endcase
  end

  assign root_start = end_go && !set_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration register, written only while idle
  assign cfg_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      find_farthest_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      find_farthest_r <= cfg_find_farthest;
    end
  end

  // point store; writes happen only while idle and reads only while
  // scanning, so no access to the same entry can overlap
  cfps_point_mem #(
    .DEPTH (FIRST_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (ld_ok),
    .wr_addr (first_count_r[AW-1:0]),
    .wr_data ({in_point_x, in_point_y, in_point_z}),
    .rd_en   (issue),
    .rd_addr (scan_idx_r),
    .rd_data (rd_data)
  );

  cfps_dist_pipe #(
    .AW (AW)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .issue_idx (scan_idx_r),
    .mem_data  (rd_data),
    .q_x       (q_x_r),
    .q_y       (q_y_r),
    .q_z       (q_z_r),
    .stat      (dstat),
    .sq        (d_sq),
    .idx       (d_idx)
  );

  // best-pair rule: first pair of a job, tie to lower first index, else order
  always_comb begin
    if ((second_count_r == '0) && (d_idx == '0)) begin
      take = 1'b1;
    end else if (d_sq == best_sq_r) begin
      take = d_idx < best_first_r;
    end else if (find_farthest_r) begin
      take = d_sq > best_sq_r;
    end else begin
      take = d_sq < best_sq_r;
    end
  end

  // job state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_count_r  <= '0;
      second_count_r <= '0;
      best_sq_r      <= '0;
      best_first_r   <= '0;
      best_second_r  <= '0;
      overflow_r     <= 1'b0;
      scan_idx_r     <= '0;
    end else if (emit) begin
      first_count_r  <= '0;
      second_count_r <= '0;
      best_sq_r      <= '0;
      best_first_r   <= '0;
      best_second_r  <= '0;
      overflow_r     <= 1'b0;
    end else begin
      if (ld_ok) begin
        first_count_r <= first_count_r + FCW'(1);
      end
      if (ld_drop || cmp_drop) begin
        overflow_r <= 1'b1;
      end
      if (cmp_skip || drain_done) begin
        second_count_r <= second_count_r + SCW'(1);
      end
      if (cmp_go) begin
        scan_idx_r <= '0;
      end else if (scan_step) begin
        scan_idx_r <= scan_idx_r + AW'(1);
      end
      if (dstat.hit && take) begin
        best_sq_r     <= d_sq;
        best_first_r  <= d_idx;
        best_second_r <= second_count_r[SIW-1:0];
      end
    end
  end

  // query point held during its scan
  always_ff @(posedge clk) begin
    if (cmp_go) begin
      q_x_r <= in_point_x;
      q_y_r <= in_point_y;
      q_z_r <= in_point_z;
    end
  end

  cfps_isqrt u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (best_sq_r),
    .busy     (root_busy),
    .root     (root)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_distance_r <= set_empty ? '0 : root;
      out_first_r    <= set_empty ? '0 : IDX_OUT_BITS'(best_first_r);
      out_second_r   <= set_empty ? '0 : IDX_OUT_BITS'(best_second_r);
      out_empty_r    <= set_empty;
      out_overflow_r <= overflow_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_distance     = out_distance_r;
  assign out_first_index  = out_first_r;
  assign out_second_index = out_second_r;
  assign out_empty_set    = out_empty_r;
  assign out_overflow     = out_overflow_r;

endmodule

>>> rtl/core/cfps_point_mem.sv
// first-set point store: one write port, one read port, registered read
// uses cfps_pkg for the point word width

module cfps_point_mem
  import cfps_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [POINT_BITS-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [POINT_BITS-1:0] rd_data
);

  logic [POINT_BITS-1:0] mem [DEPTH];
  logic [POINT_BITS-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/cfps_dist_pipe.sv
// squared distance pipeline: tag align, abs diff, square, sum
// uses cfps_pkg; fed by the read port of cfps_point_mem

module cfps_dist_pipe
  import cfps_pkg::*;
#(
  parameter int AW = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         issue,
  input  logic [AW-1:0]                issue_idx,
  input  logic [POINT_BITS-1:0]        mem_data,
  input  logic signed [COORD_BITS-1:0] q_x,
  input  logic signed [COORD_BITS-1:0] q_y,
  input  logic signed [COORD_BITS-1:0] q_z,
  output dist_stat_t                   stat,
  output logic [SQ_BITS-1:0]           sq,
  output logic [AW-1:0]                idx
);

  logic                      v0_r, v1_r, v2_r, v3_r;
  logic [AW-1:0]             i0_r, i1_r, i2_r, i3_r;
  logic [COORD_BITS-1:0]     dx_r, dy_r, dz_r;
  logic [2*COORD_BITS-1:0]   sx_r, sy_r, sz_r;
  logic [SQ_BITS-1:0]        sum_r;
  logic signed [COORD_BITS-1:0] m_x, m_y, m_z;

  assign m_x = mem_data[3*COORD_BITS-1:2*COORD_BITS];
  assign m_y = mem_data[2*COORD_BITS-1:COORD_BITS];
  assign m_z = mem_data[COORD_BITS-1:0];

  // valid flags of each stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    // index rides along with the memory read
    i0_r <= issue_idx;
    // per-axis magnitude of difference
    i1_r <= i0_r;
    dx_r <= abs_diff(m_x, q_x);
    dy_r <= abs_diff(m_y, q_y);
    dz_r <= abs_diff(m_z, q_z);
    // squares
    i2_r <= i1_r;
    sx_r <= dx_r * dx_r;
    sy_r <= dy_r * dy_r;
    sz_r <= dz_r * dz_r;
    // sum of squares
    i3_r  <= i2_r;
    sum_r <= SQ_BITS'(sx_r) + SQ_BITS'(sy_r) + SQ_BITS'(sz_r);
  end

  assign stat.busy = v0_r | v1_r | v2_r | v3_r;
  assign stat.hit  = v3_r;
  assign sq        = sum_r;
  assign idx       = i3_r;

endmodule

>>> rtl/core/cfps_isqrt.sv
// integer square root, two radicand bits per cycle
// uses cfps_pkg for the squared distance and root widths

module cfps_isqrt
  import cfps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [SQ_BITS-1:0]   radicand,
  output logic                 busy,
  output logic [ROOT_BITS-1:0] root
);

  logic               busy_r, busy_nxt;
  logic [SQ_BITS-1:0] n_r, n_nxt;
  logic [SQ_BITS-1:0] res_r, res_nxt;
  logic [SQ_BITS-1:0] bit_r, bit_nxt;
  logic [SQ_BITS-1:0] trial;

  assign trial = res_r + bit_r;

  // one digit step
  always_comb begin
    busy_nxt = busy_r;
    n_nxt    = n_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      n_nxt    = radicand;
      res_nxt  = '0;
      bit_nxt  = SQ_BITS'(1) << (SQ_BITS - 2);
    end else if (busy_r) begin
      if (n_r >= trial) begin
        n_nxt   = n_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      // lowest digit pair done
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign busy = busy_r;
  assign root = res_r[ROOT_BITS-1:0];

endmodule

>>> rtl/core/cfps_checker.sv
// port-level checks of closest_farthest_pair_search, with its bind
// uses cfps_pkg for field widths and mode codes

module cfps_checker
  import cfps_pkg::*;
(
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [MODE_BITS-1:0]         in_mode,
  input logic signed [COORD_BITS-1:0] in_point_x,
  input logic signed [COORD_BITS-1:0] in_point_y,
  input logic signed [COORD_BITS-1:0] in_point_z,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ROOT_BITS-1:0]         out_distance,
  input logic [IDX_OUT_BITS-1:0]      out_first_index,
  input logic [IDX_OUT_BITS-1:0]      out_second_index,
  input logic                         out_empty_set,
  input logic                         out_overflow
);

  // a stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_mode)
      && $stable(in_point_x) && $stable(in_point_y) && $stable(in_point_z))
    else $error("input beat changed while stalled");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance)
      && $stable(out_first_index) && $stable(out_second_index)
      && $stable(out_empty_set) && $stable(out_overflow))
    else $error("result beat changed while stalled");

  // an empty job reports all zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_set |-> out_distance == '0
      && out_first_index == '0 && out_second_index == '0)
    else $error("empty job result not zero");

  // an end beat blocks the input while the result is formed
  a_end_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_END |=> !in_ready)
    else $error("input open right after end beat");

  // a new result appears only after the input was closed
  a_result_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while input was open");

endmodule

bind closest_farthest_pair_search cfps_checker u_cfps_checker (.*);
